@@ hw/rtl/pcnc_pkg.sv @@
// Shared types and codes for the palette lookup table and nearest-color search.
package pcnc_pkg;

  // Input word operation codes.
  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_MAP   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Result word kinds.
  typedef enum logic [1:0] {
    KIND_WRITTEN = 2'd0,
    KIND_IGNORED = 2'd1,
    KIND_NEAREST = 2'd2,
    KIND_READ    = 2'd3
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_READ  = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DRAIN = 2'd3
  } state_e;

  localparam int unsigned ColorW   = 8;
  localparam int unsigned VersionW = 32;
  localparam int unsigned DistW    = 18;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;          // store one entry and load a write result
    logic rd;          // issue a table read for a read word
    logic scan_start;  // latch the target color and reset the search
    logic scan_issue;  // read the next entry of the search
    logic res_read;    // load the read result
    logic res_scan;    // load the nearest-index result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic res_busy;    // result register stays occupied at this edge
    logic scan_last;   // the search reads its final entry in this cycle
    logic pipe_busy;   // distance pipeline still holds entries
  } sts_t;

  // One result word.
  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          index;
    logic [ColorW-1:0]   red;
    logic [ColorW-1:0]   green;
    logic [ColorW-1:0]   blue;
    logic [VersionW-1:0] version;
  } res_t;

endpackage

@@ hw/rtl/pcnc_ctrl.sv @@
// Controller state machine that sequences table writes, reads and the search.
module pcnc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       func_i,
  input  pcnc_pkg::sts_t   sts_i,
  output logic             in_stall_o,
  output pcnc_pkg::cmd_t   cmd_o
);

  pcnc_pkg::state_e state_q, state_d;
  logic accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcnc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != pcnc_pkg::ST_IDLE) || sts_i.res_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcnc_pkg::ST_IDLE: begin
        if (accept && func_i == pcnc_pkg::FUNC_READ) begin
          state_d = pcnc_pkg::ST_READ;
        end else if (accept && func_i == pcnc_pkg::FUNC_MAP) begin
          state_d = pcnc_pkg::ST_SCAN;
        end
      end
      pcnc_pkg::ST_READ: begin
        state_d = pcnc_pkg::ST_IDLE;
      end
      pcnc_pkg::ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = pcnc_pkg::ST_DRAIN;
        end
      end
      pcnc_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = pcnc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcnc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      pcnc_pkg::ST_IDLE: begin
        cmd_o.wr         = accept && (func_i == pcnc_pkg::FUNC_WRITE);
        cmd_o.rd         = accept && (func_i == pcnc_pkg::FUNC_READ);
        cmd_o.scan_start = accept && (func_i == pcnc_pkg::FUNC_MAP);
      end
      pcnc_pkg::ST_READ: begin
        cmd_o.res_read = 1'b1;
      end
      pcnc_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
      end
      pcnc_pkg::ST_DRAIN: begin
        cmd_o.res_scan = !sts_i.pipe_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/pcnc_datapath.sv @@
// Datapath: color table, change counter, distance pipeline and result registers.
module pcnc_datapath #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcnc_pkg::cmd_t                 cmd_i,
  output pcnc_pkg::sts_t                 sts_o,
  input  logic signed [8:0]              run_start_i,
  input  logic [7:0]                     run_offset_i,
  input  logic                           last_in_run_i,
  input  logic [7:0]                     entry_index_i,
  input  logic [pcnc_pkg::ColorW-1:0]    red_i,
  input  logic [pcnc_pkg::ColorW-1:0]    green_i,
  input  logic [pcnc_pkg::ColorW-1:0]    blue_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output pcnc_pkg::res_t                 out_o
);

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned ColW = 3 * pcnc_pkg::ColorW;

  // Table storage; entries without their valid bit read as black.
  logic [ColW-1:0] mem_q [ENTRIES];
  logic [ENTRIES-1:0] vld_q;

  logic [pcnc_pkg::VersionW-1:0] cnt_q, cnt_d;
  logic run_any_q, run_any_d;

  logic signed [9:0] pos;
  logic              pos_ok;
  logic              idx_ok;
  logic [IW-1:0]     rd_addr;
  logic              rd_en;

  logic [ColW-1:0]   rd_q;
  logic              rd_ok_q;
  logic [ColW-1:0]   rd_col;
  logic [7:0]        idx_q;

  logic [IW-1:0]     scan_cnt_q;
  logic [pcnc_pkg::ColorW-1:0] tgt_r_q, tgt_g_q, tgt_b_q;
  logic              p1_q, p2_q;
  logic [IW-1:0]     p1_idx_q, p2_idx_q;
  logic [15:0]       sq_r_q, sq_g_q, sq_b_q;
  logic [pcnc_pkg::DistW-1:0] sum_sq;
  logic [pcnc_pkg::DistW-1:0] min_sq_q;
  logic [IW-1:0]     best_idx_q;

  pcnc_pkg::res_t    res_q, res_d;
  logic              res_vld_q;
  logic              res_load;
  logic              res_move;
  logic              out_vld_q;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d * d;
  endfunction

  // Write position: sign-extended start plus offset.
  assign pos    = {run_start_i[8], run_start_i} + $signed({2'b00, run_offset_i});
  assign pos_ok = !pos[9] && (pos[8:0] < 9'(ENTRIES));
  assign idx_ok = {1'b0, entry_index_i} < 9'(ENTRIES);

  assign rd_en   = cmd_i.rd || cmd_i.scan_issue;
  assign rd_addr = cmd_i.scan_issue ? scan_cnt_q : entry_index_i[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && pos_ok) begin
      mem_q[pos[IW-1:0]] <= {red_i, green_i, blue_i};
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (cmd_i.wr && pos_ok) begin
        vld_q[pos[IW-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_q <= vld_q[rd_addr] && (cmd_i.scan_issue || idx_ok);
      end
    end
  end

  assign rd_col = rd_ok_q ? rd_q : '0;

  // Change counter and run tracking.
  always_comb begin
    cnt_d     = cnt_q;
    run_any_d = run_any_q;
    if (cmd_i.wr) begin
      if (last_in_run_i) begin
        run_any_d = 1'b0;
        if (run_any_q || pos_ok) begin
          cnt_d = cnt_q + 1'b1;
        end
      end else begin
        run_any_d = run_any_q || pos_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= pcnc_pkg::VersionW'(1);
      run_any_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      run_any_q <= run_any_d;
    end
  end

  // Search: read stage, squared-difference stage, compare stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      p1_q       <= 1'b0;
      p2_q       <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      p1_q <= cmd_i.scan_issue;
      p2_q <= p1_q;
    end
  end

  assign sum_sq = pcnc_pkg::DistW'(sq_r_q) + pcnc_pkg::DistW'(sq_g_q)
                + pcnc_pkg::DistW'(sq_b_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      tgt_r_q    <= red_i;
      tgt_g_q    <= green_i;
      tgt_b_q    <= blue_i;
      min_sq_q   <= '1;
      best_idx_q <= '0;
    end else if (p2_q && (sum_sq < min_sq_q)) begin
      min_sq_q   <= sum_sq;
      best_idx_q <= p2_idx_q;
    end
    if (cmd_i.rd) begin
      idx_q <= entry_index_i;
    end
    p1_idx_q <= scan_cnt_q;
    if (p1_q) begin
      sq_r_q   <= sq_diff(rd_col[23:16], tgt_r_q);
      sq_g_q   <= sq_diff(rd_col[15:8], tgt_g_q);
      sq_b_q   <= sq_diff(rd_col[7:0], tgt_b_q);
      p2_idx_q <= p1_idx_q;
    end
  end

  // Result register feeding the output register.
  assign res_load = cmd_i.wr || cmd_i.res_read || cmd_i.res_scan;
  assign res_move = res_vld_q && (!out_vld_q || !out_stall_i);

  always_comb begin
    res_d         = '0;
    res_d.version = cnt_q;
    if (cmd_i.wr) begin
      res_d.version = cnt_d;
      if (pos_ok) begin
        res_d.kind  = pcnc_pkg::KIND_WRITTEN;
        res_d.index = pos[7:0];
        res_d.red   = red_i;
        res_d.green = green_i;
        res_d.blue  = blue_i;
      end else begin
        res_d.kind  = pcnc_pkg::KIND_IGNORED;
      end
    end else if (cmd_i.res_read) begin
      res_d.kind  = pcnc_pkg::KIND_READ;
      res_d.index = idx_q;
      res_d.red   = rd_col[23:16];
      res_d.green = rd_col[15:8];
      res_d.blue  = rd_col[7:0];
    end else begin
      res_d.kind  = pcnc_pkg::KIND_NEAREST;
      res_d.index = 8'(best_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_move) begin
        res_vld_q <= 1'b0;
      end
      if (res_move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
    if (res_move) begin
      out_o <= res_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign sts_o.res_busy  = res_vld_q && !res_move;
  assign sts_o.scan_last = cmd_i.scan_issue && (scan_cnt_q == IW'(ENTRIES - 1));
  assign sts_o.pipe_busy = p1_q || p2_q;

  // A new result never overwrites one that has not moved on.
  a_res_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_vld_q || res_move))
    else $error("result register overwritten while occupied");

  // Only a write word may change the version counter.
  a_cnt_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.wr |=> $stable(cnt_q))
    else $error("version changed without a write");

  // A write moves the version by at most one.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
    else $error("version stepped by more than one");

  // The search result is loaded only once the distance pipeline is empty.
  a_scan_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_scan |-> !p1_q && !p2_q && !cmd_i.scan_issue)
    else $error("search result taken before the pipeline drained");

endmodule

@@ hw/rtl/palette_clut_nearest_color_unit.sv @@
// Top level of the palette lookup table with nearest-color search.
//
// Input words arrive on in_valid_i / in_stall_o and are taken at a rising edge
// where valid is high and stall is low. Each taken word, except one with the
// unused operation code, gives exactly one result word on out_valid_o /
// out_stall_i. A write word stores one color of a run; a read word also passes
// through the registered table read. A nearest-color word walks the table one
// entry per cycle through a three-stage distance pipeline (read, squared
// differences, compare), and its result is loaded once that pipeline has
// drained. One word is worked on at a time.
// Results pass through a result register and an output register, so a new
// word is taken while the previous result still waits at the output; out_valid_o
// rises when a result moves from the result register to the output register.
// Without stalls a new word is taken every cycle after a write, while a read or
// a search holds off the next word until its result has been loaded.
// While the receiver stalls, the output word holds and, once both result
// registers are full, in_stall_o rises.
// Reset clears every table entry to black through per-entry valid bits at
// once, with no clearing pass, sets the version to 1 and ends any open run.
module palette_clut_nearest_color_unit #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        func_i,
  input  logic signed [8:0] run_start_i,
  input  logic [7:0]        run_offset_i,
  input  logic              last_in_run_i,
  input  logic [7:0]        entry_index_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [7:0]        out_index_o,
  output logic [7:0]        out_red_o,
  output logic [7:0]        out_green_o,
  output logic [7:0]        out_blue_o,
  output logic [31:0]       version_o
);

  pcnc_pkg::cmd_t cmd;
  pcnc_pkg::sts_t sts;
  pcnc_pkg::res_t out_word;

  // The controller decides which word is taken and when each step runs.
  pcnc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // The datapath holds the table, the version counter and the result path.
  pcnc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .run_start_i   (run_start_i),
    .run_offset_i  (run_offset_i),
    .last_in_run_i (last_in_run_i),
    .entry_index_i (entry_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .out_o         (out_word)
  );

  // The result word is split onto its field ports.
  assign kind_o      = out_word.kind;
  assign out_index_o = out_word.index;
  assign out_red_o   = out_word.red;
  assign out_green_o = out_word.green;
  assign out_blue_o  = out_word.blue;
  assign version_o   = out_word.version;

endmodule
